// ===== rtl/o16iir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// o16iir_pkg: constants and coefficient ROM of the order-16 IIR low-pass
// Fixed-point formats, accumulator sizes and the Q8.40 coefficient tables.
// Each coefficient is m * 10^-e rounded half away from zero to 40 fraction
// bits and then given the sign of m.
// ----------------------------------------------------------------------------
package o16iir_pkg;

   localparam int COEF_W     = 48;   // Q8.40 coefficients and output history
   localparam int FRAC       = 40;
   localparam int ACC_W      = 64;   // sum of floored products, cannot overflow
   localparam int ROM_TAPS   = 17;
   localparam int COEF_IDX_W = 5;
   localparam int HALF_W     = 24;   // multiplier splits each operand in two
   localparam int MUL_IN_W   = HALF_W + 1;
   localparam int MUL_W      = 2 * MUL_IN_W;
   localparam int PROD_W     = 2 * COEF_W;

   // powers of ten and their doubles for the rounding divide
   localparam logic [127:0] P7  = 128'd10_000_000;
   localparam logic [127:0] P8  = 128'd100_000_000;
   localparam logic [127:0] P9  = 128'd1_000_000_000;
   localparam logic [127:0] P10 = 128'd10_000_000_000;
   localparam logic [127:0] P11 = 128'd100_000_000_000;
   localparam logic [127:0] P12 = 128'd1_000_000_000_000;
   localparam logic [127:0] P14 = 128'd100_000_000_000_000;
   localparam logic [127:0] D7  = P7  * 2;
   localparam logic [127:0] D8  = P8  * 2;
   localparam logic [127:0] D9  = P9  * 2;
   localparam logic [127:0] D10 = P10 * 2;
   localparam logic [127:0] D11 = P11 * 2;
   localparam logic [127:0] D12 = P12 * 2;
   localparam logic [127:0] D14 = P14 * 2;

   // numerator, b[0] to b[16]
   localparam logic signed [COEF_W-1:0] COEF_B [ROM_TAPS] = '{
      48'(((128'd682387827 << 41) + P14) / D14),
      48'(((128'd109182052 << 41) + P12) / D12),
      48'(((128'd818865432 << 41) + P12) / D12),
      48'(((128'd382137182 << 41) + P11) / D11),
      48'(((128'd124194585 << 41) + P10) / D10),
      48'(((128'd298067015 << 41) + P10) / D10),
      48'(((128'd546456166 << 41) + P10) / D10),
      48'(((128'd780651718 << 41) + P10) / D10),
      48'(((128'd878233165 << 41) + P10) / D10),
      48'(((128'd780651718 << 41) + P10) / D10),
      48'(((128'd546456166 << 41) + P10) / D10),
      48'(((128'd298067015 << 41) + P10) / D10),
      48'(((128'd124194585 << 41) + P10) / D10),
      48'(((128'd382137182 << 41) + P11) / D11),
      48'(((128'd818865432 << 41) + P12) / D12),
      48'(((128'd109182052 << 41) + P12) / D12),
      48'(((128'd682387827 << 41) + P14) / D14)
   };

   // denominator, a[0] to a[16]; a[0] is never used by the recursion
   localparam logic signed [COEF_W-1:0] COEF_A [ROM_TAPS] = '{
      48'(((128'd10000000 << 41) + P7) / D7),
      48'(-(((128'd29343348 << 41) + P7) / D7)),
      48'(((128'd60569754 << 41) + P7) / D7),
      48'(-(((128'd84904690 << 41) + P7) / D7)),
      48'(((128'd94275398 << 41) + P7) / D7),
      48'(-(((128'd82493067 << 41) + P7) / D7)),
      48'(((128'd59339728 << 41) + P7) / D7),
      48'(-(((128'd34944806 << 41) + P7) / D7)),
      48'(((128'd17052743 << 41) + P7) / D7),
      48'(-(((128'd68370658 << 41) + P8) / D8)),
      48'(((128'd22441590 << 41) + P8) / D8),
      48'(-(((128'd59260190 << 41) + P9) / D9)),
      48'(((128'd12332326 << 41) + P9) / D9),
      48'(-(((128'd19465445 << 41) + P10) / D10)),
      48'(((128'd21958887 << 41) + P11) / D11),
      48'(-(((128'd15769092 << 41) + P12) / D12)),
      48'(((128'd54263586 << 41) + P14) / D14)
   };

endpackage
`default_nettype wire

// ===== rtl/o16iir_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// o16iir_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module o16iir_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/order16_iir_lowpass.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// order16_iir_lowpass: fixed-coefficient direct-form-I IIR low-pass filter
// Keeps the last TAPS-1 input and output samples in one history RAM and
// forms y = sum b[i]*x[n-i] - sum a[i]*y[n-i] on one shared multiplier.
//
//   channel | ports      | tdata (low bit up)       | tuser
//   --------+------------+--------------------------+-----------
//   request | req_t*     | sample_in, zero padding  | -
//   result  | rsp_t*     | sample_out, zero padding | clipped
//
// Sequence: each of the 2*TAPS-1 products is built from four partial products
//   on the shared 25x25 multiplier; the multiply pipeline then drains, the
//   new entry is written back and the result loaded. A new word is taken
//   only after the result of the last one has been loaded.
// Reset: clears the history valid bits, so the whole history reads as zero.
// Stalls: a result waiting on rsp_tready does not stop the next request
//   being taken; only the write of the following result waits for it.
// ----------------------------------------------------------------------------
module order16_iir_lowpass #(
   parameter int TAPS         = 17,
   parameter int SAMPLE_WIDTH = 24,
   localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // sample_in, then zero padding
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // sample_out, then zero padding
   output logic               rsp_tuser    // clipped
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int CW      = o16iir_pkg::COEF_W;
   localparam int HW      = o16iir_pkg::HALF_W;
   localparam int MIW     = o16iir_pkg::MUL_IN_W;
   localparam int MW      = o16iir_pkg::MUL_W;
   localparam int PW      = o16iir_pkg::PROD_W;
   localparam int AC      = o16iir_pkg::ACC_W;
   localparam int CIW     = o16iir_pkg::COEF_IDX_W;
   localparam int HIST    = TAPS - 1;
   localparam int ADDR_W  = $clog2(HIST);
   localparam int TAP_W   = $clog2(TAPS);
   localparam int WORD_W  = CW + SW;
   localparam int BSHIFT  = SW - 1;
   localparam int OSHIFT  = o16iir_pkg::FRAC - (SW - 1);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HIST - 1);
   localparam logic [TAP_W-1:0]  LAST_TAP  = TAP_W'(HIST);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_SAT,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef enum logic {
      TERM_B,
      TERM_A
   } term_type;

   // sequencer and registered outputs
   state_type         state_ff,    state_in;
   logic [TAP_W-1:0]  tap_ff,      tap_in;
   logic [1:0]        part_ff,     part_in;
   term_type          kind_ff,     kind_in;
   logic [ADDR_W-1:0] rd_ptr_ff,   rd_ptr_in;
   logic [ADDR_W-1:0] head_ff,     head_in;
   logic [HIST-1:0]   valid_ff,    valid_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              mv_ff,       mv_in;
   logic [1:0]        mpart_ff,    mpart_in;
   term_type          mkind_ff,    mkind_in;
   logic              pdone_ff,    pdone_in;
   term_type          pkind_ff,    pkind_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [SW-1:0]     rsp_sample_ff, rsp_sample_in;
   logic              rsp_clip_ff,   rsp_clip_in;

   // datapath
   logic [SW-1:0]            x_ff;
   logic signed [MW-1:0]     mul_ff;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [AC-1:0]     acc_ff,  acc_in;
   logic [CW-1:0]            y_ff,    y_in;
   logic                     clip_ff, clip_in;

   logic                     accept;
   logic                     load_rsp;
   logic                     ram_we, ram_re;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [WORD_W-1:0]        ram_rd_data;
   logic [SW-1:0]            hist_x;
   logic [CW-1:0]            hist_y;
   logic [SW-1:0]            data_x;
   logic [CW-1:0]            op_coef, op_data;
   logic signed [MIW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]     mul_ext, mul_shifted;
   logic signed [PW-1:0]     term_full;
   logic signed [AC-1:0]     term;
   logic [AC-CW:0]           acc_top;
   logic [CW-1:0]            y_shr;
   logic [CW-SW:0]           y_top;
   logic [SW-1:0]            sample_sat;
   logic                     out_clip;

   assign accept   = req_tvalid && req_tready;
   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   // ---------------------------------------------------------------- history
   o16iir_ram #(
      .WIDTH (WORD_W),
      .DEPTH (HIST)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (rd_ptr_ff),
      .wr_data ({y_ff, x_ff}),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // an entry never written since reset reads as zero
   assign hist_x = rd_valid_ff ? ram_rd_data[SW-1:0] : '0;
   assign hist_y = rd_valid_ff ? ram_rd_data[WORD_W-1:SW] : '0;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in    = state_ff;
      tap_in      = tap_ff;
      part_in     = part_ff;
      kind_in     = kind_ff;
      rd_ptr_in   = rd_ptr_ff;
      head_in     = head_ff;
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      ram_re      = 1'b0;
      ram_we      = 1'b0;
      ram_rd_addr = rd_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // fetch the newest history entry while the current sample
               // goes through first
               ram_re      = 1'b1;
               ram_rd_addr = head_ff;
               state_in    = ST_RUN;
               tap_in      = '0;
               part_in     = '0;
               kind_in     = TERM_B;
            end
         end
         ST_RUN: begin
            part_in = part_ff + 2'd1;
            if (part_ff == 2'd3) begin
               if (kind_ff == TERM_B) begin
                  if (tap_ff == '0) begin
                     tap_in = tap_ff + 1'b1;
                  end else begin
                     kind_in = TERM_A;
                  end
               end else if (tap_ff != LAST_TAP) begin
                  // step one sample further back
                  tap_in      = tap_ff + 1'b1;
                  kind_in     = TERM_B;
                  ram_re      = 1'b1;
                  ram_rd_addr = (rd_ptr_ff == '0) ? LAST_ADDR : rd_ptr_ff - 1'b1;
               end else begin
                  state_in = ST_SAT;
               end
            end
         end
         ST_SAT: begin
            // wait for the multiply pipeline to drain
            if (!mv_ff && !pdone_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // overwrite the oldest entry, which becomes the newest
            ram_we                = 1'b1;
            head_in               = rd_ptr_ff;
            valid_in[rd_ptr_ff]   = 1'b1;
            state_in              = ST_EMIT;
         end
         ST_EMIT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ram_re) begin
         rd_ptr_in   = ram_rd_addr;
         rd_valid_in = valid_ff[ram_rd_addr];
      end
   end

   assign mv_in    = (state_ff == ST_RUN);
   assign mpart_in = part_ff;
   assign mkind_in = kind_ff;
   assign pdone_in = mv_ff && (mpart_ff == 2'd3);
   assign pkind_in = mkind_ff;

   // ---------------------------------------------------------------- result
   // floor to the sample format, then saturate
   assign y_shr      = $unsigned($signed(y_ff) >>> OSHIFT);
   assign y_top      = y_shr[CW-1:SW-1];
   assign out_clip   = (y_top != '0) && (y_top != '1);
   assign sample_sat = !out_clip ? y_shr[SW-1:0]
                     : (y_shr[CW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

   assign rsp_sample_in = load_rsp ? sample_sat : rsp_sample_ff;
   assign rsp_clip_in   = load_rsp ? (clip_ff || out_clip) : rsp_clip_ff;
   assign rsp_tvalid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_ff        <= '0;
         part_ff       <= '0;
         kind_ff       <= TERM_B;
         rd_ptr_ff     <= '0;
         head_ff       <= '0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         mv_ff         <= 1'b0;
         mpart_ff      <= '0;
         mkind_ff      <= TERM_B;
         pdone_ff      <= 1'b0;
         pkind_ff      <= TERM_B;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         part_ff       <= part_in;
         kind_ff       <= kind_in;
         rd_ptr_ff     <= rd_ptr_in;
         head_ff       <= head_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
         mv_ff         <= mv_in;
         mpart_ff      <= mpart_in;
         mkind_ff      <= mkind_in;
         pdone_ff      <= pdone_in;
         pkind_ff      <= pkind_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_sample_ff <= rsp_sample_in;
         rsp_clip_ff   <= rsp_clip_in;
      end
   end

   // ---------------------------------------------------------------- multiply
   assign data_x  = (tap_ff == '0) ? x_ff : hist_x;
   assign op_data = (kind_ff == TERM_A) ? hist_y : {{(CW-SW){data_x[SW-1]}}, data_x};
   assign op_coef = (kind_ff == TERM_A) ? o16iir_pkg::COEF_A[CIW'(tap_ff)]
                                        : o16iir_pkg::COEF_B[CIW'(tap_ff)];

   // partial products: low halves unsigned, high halves signed
   assign mul_a = part_ff[1] ? {op_coef[CW-1], op_coef[CW-1:HW]} : {1'b0, op_coef[HW-1:0]};
   assign mul_b = part_ff[0] ? {op_data[CW-1], op_data[CW-1:HW]} : {1'b0, op_data[HW-1:0]};

   assign mul_ext = {{(PW-MW){mul_ff[MW-1]}}, mul_ff};

   always_comb begin
      case (mpart_ff)
         2'd0:    mul_shifted = mul_ext;
         2'd3:    mul_shifted = mul_ext <<< (2 * HW);
         default: mul_shifted = mul_ext <<< HW;
      endcase
   end

   assign prod_in = (mpart_ff == 2'd0) ? mul_shifted : prod_ff + mul_shifted;

   // floor each product to 40 fraction bits before it joins the sum
   assign term_full = (pkind_ff == TERM_B) ? (prod_ff >>> BSHIFT)
                                           : (prod_ff >>> o16iir_pkg::FRAC);
   assign term      = $signed(term_full[AC-1:0]);
   assign acc_in    = (pkind_ff == TERM_B) ? acc_ff + term : acc_ff - term;

   // saturate the sum to the 48-bit history format
   assign acc_top = acc_ff[AC-1:CW-1];
   assign clip_in = (acc_top != '0) && (acc_top != '1);
   assign y_in    = !clip_in ? acc_ff[CW-1:0]
                  : (acc_ff[AC-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_tdata[SW-1:0];
      end
      if (mv_ff) begin
         prod_ff <= prod_in;
      end
      if (accept) begin
         acc_ff <= '0;
      end else if (pdone_ff) begin
         acc_ff <= acc_in;
      end
      if (state_ff == ST_SAT) begin
         y_ff    <= y_in;
         clip_ff <= clip_in;
      end
      mul_ff <= mul_a * mul_b;
   end

   // ---------------------------------------------------------------- ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_sample_ff);
   assign rsp_tuser  = rsp_clip_ff;

`ifndef ASSERT_OFF
   // a new word starts with the current-sample term
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (tap_ff == '0) && (part_ff == 2'd0)
                 && (kind_ff == TERM_B))
      else $error("sequence did not start at the first term");

   // the write-back slot is the oldest entry
   a_wr_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |->
         (rd_ptr_ff == ((head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1)))
      else $error("history write does not hit the oldest entry");

   // the result leaves only after the multiply pipeline has emptied
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE || state_ff == ST_EMIT) |-> (!mv_ff && !pdone_ff))
      else $error("result formed with products still in flight");

   // a finished product follows its fourth partial product
   a_prod: assert property (@(posedge clock) disable iff (reset)
      pdone_ff |-> $past(mv_ff && (mpart_ff == 2'd3)))
      else $error("product completed without all partial products");

   // the RAM is never read and written in the same cycle
   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("history read and write collide");
`endif

endmodule
`default_nettype wire
